>>> hdl/arpd_pkg.sv
`default_nettype none

package arpd_pkg;

    // Sample, envelope and arithmetic widths
    localparam int CHANNELS  = 2;
    localparam int SAMP_W    = 16;
    localparam int MAG_W     = SAMP_W + 1;
    localparam int ENV_W     = 32;
    localparam int M31_W     = ENV_W + 1;
    localparam int COEF_W    = 24;
    localparam int LEVEL_W   = 16;
    localparam int DIFF_W    = 34;
    localparam int DLO_W     = 16;
    localparam int DHI_W     = DIFF_W - DLO_W;
    localparam int PROD_W    = COEF_W + 1 + DHI_W;
    localparam int ACC_W     = 59;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int ACT_W     = 2;

    // Register reset values
    localparam logic [COEF_W-1:0]  ATTACK_RESET  = 24'd16770226;
    localparam logic [COEF_W-1:0]  RELEASE_RESET = 24'd16776983;
    localparam logic [LEVEL_W-1:0] FLOOR_RESET   = 16'd328;
    localparam logic [LEVEL_W-1:0] GAIN_RESET    = 16'd20480;
    localparam logic [ACT_W-1:0]   ACTIVE_RESET  = 2'd2;

    // Full scale of the presence output (1.0 in Q1.15)
    localparam logic [LEVEL_W-1:0] PRES_MAX = 16'd32768;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK   = 3'd0,
        CFG_RELEASE  = 3'd1,
        CFG_FLOOR    = 3'd2,
        CFG_GAIN     = 3'd3,
        CFG_CHANNELS = 3'd4
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_LO,
        ST_ENV_HI,
        ST_ENV_SUM,
        ST_PRES_DIFF,
        ST_PRES_LO,
        ST_PRES_HI,
        ST_PRES_SUM,
        ST_OUT
    } state_t;

    // Rectify a Q1.15 sample; the most negative code gives 32768
    function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAMP_W-1:0] s);
        logic signed [MAG_W-1:0] w;
        w = MAG_W'(s);
        return s[SAMP_W-1] ? MAG_W'(-w) : MAG_W'(w);
    endfunction

    // True when the second channel takes part in the peak search
    function automatic logic use_second(input logic [ACT_W-1:0] act);
        return (act >= 2'd2) && (CHANNELS >= 2);
    endfunction

endpackage

`default_nettype wire

>>> hdl/arpd_mac.sv
`default_nettype none

module arpd_mac (
    input  wire logic                                  aclk,
    input  wire logic [arpd_pkg::COEF_W-1:0]           mul_a,
    input  wire logic signed [arpd_pkg::DHI_W-1:0]     mul_b,
    output logic signed [arpd_pkg::PROD_W-1:0]         prod_reg
);
    import arpd_pkg::*;

    logic signed [COEF_W:0] a_signed;

    assign a_signed = $signed({1'b0, mul_a});

    // Multiply an unsigned coefficient by a signed half word, register the product
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a_signed * mul_b);
    end

endmodule

`default_nettype wire

>>> hdl/attack_release_presence_detector.sv
`default_nettype none
// Frame without block_end: accepted in IDLE, then ENV_LO, ENV_HI and ENV_SUM; the envelope
// is updated in ENV_SUM and the block returns to IDLE, ready for the next frame.
// With block_end the PRES states follow; OUT waits for a free output and then sets m_valid.
// All products go through one registered 25x18 multiplier, two passes per product.
// Reset (aresetn low, synchronous) clears the envelope, drops m_valid and reloads defaults.
module attack_release_presence_detector (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [arpd_pkg::SAMP_W-1:0]    s_sample_first,
    input  wire logic signed [arpd_pkg::SAMP_W-1:0]    s_sample_second,
    input  wire logic                                  s_block_end,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [arpd_pkg::LEVEL_W-1:0]               m_presence,
    output logic [arpd_pkg::LEVEL_W-1:0]               m_envelope_level,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [arpd_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [arpd_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import arpd_pkg::*;

    state_t state_reg, state_next;

    logic [COEF_W-1:0]  attack_reg, release_reg;
    logic [LEVEL_W-1:0] floor_reg, gain_reg;
    logic [ACT_W-1:0]   active_reg;
    logic [ENV_W-1:0]   env_reg;

    logic [COEF_W-1:0]        coef_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     block_end_reg;
    logic [LEVEL_W-1:0]       pres_reg;

    logic                     m_valid_reg;
    logic [LEVEL_W-1:0]       m_presence_reg, m_envelope_level_reg;

    logic                     accept;
    logic                     out_free;
    logic [MAG_W-1:0]         mag_first, mag_second, mag_peak;
    logic [M31_W-1:0]         m31;
    logic                     rising;

    logic [COEF_W-1:0]        mul_a;
    logic signed [DHI_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext, acc_sum;
    logic                     sum_step;
    logic [ACC_W-1:0]         acc_bits;
    logic                     diff_pos;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Peak magnitude of the active channels, widened to Q1.31
    assign mag_first  = magnitude(s_sample_first);
    assign mag_second = magnitude(s_sample_second);
    assign mag_peak   = (use_second(active_reg) && (mag_second > mag_first))
                        ? mag_second : mag_first;
    assign m31        = {mag_peak, 16'b0};
    assign rising     = m31 > {1'b0, env_reg};

    // Shared multiplier
    arpd_mac u_mac (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    // Shared accumulator adder; upper half products enter shifted by 16
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_sum  = acc_reg + (sum_step ? (prod_ext <<< DLO_W) : prod_ext);
    assign acc_bits = acc_sum;
    assign diff_pos = !diff_reg[DIFF_W-1] && (diff_reg != '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_ENV_LO;
            ST_ENV_LO:    state_next = ST_ENV_HI;
            ST_ENV_HI:    state_next = ST_ENV_SUM;
            ST_ENV_SUM:   state_next = block_end_reg ? ST_PRES_DIFF : ST_IDLE;
            ST_PRES_DIFF: state_next = ST_PRES_LO;
            ST_PRES_LO:   state_next = ST_PRES_HI;
            ST_PRES_HI:   state_next = ST_PRES_SUM;
            ST_PRES_SUM:  state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake and multiplier operand select
    always_comb begin
        s_ready  = 1'b0;
        mul_a    = coef_reg;
        mul_b    = $signed({2'b0, diff_reg[DLO_W-1:0]});
        sum_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:     s_ready = 1'b1;
            ST_ENV_HI,
            ST_PRES_HI:  mul_b = diff_reg[DIFF_W-1:DLO_W];
            ST_ENV_SUM,
            ST_PRES_SUM: sum_step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= ATTACK_RESET;
            release_reg <= RELEASE_RESET;
            floor_reg   <= FLOOR_RESET;
            gain_reg    <= GAIN_RESET;
            active_reg  <= ACTIVE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_ATTACK:   attack_reg  <= cfg_data[COEF_W-1:0];
                CFG_RELEASE:  release_reg <= cfg_data[COEF_W-1:0];
                CFG_FLOOR:    floor_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_GAIN:     gain_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_CHANNELS: active_reg  <= cfg_data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // Envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg <= '0;
        end else if (state_reg == ST_ENV_SUM) begin
            env_reg <= acc_bits[ENV_W+23:24];
        end
    end

    // Working registers of the sequencer
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    coef_reg      <= rising ? attack_reg : release_reg;
                    diff_reg      <= $signed({2'b0, env_reg}) - $signed({1'b0, m31});
                    acc_reg       <= $signed(ACC_W'({m31, 24'b0}));
                    block_end_reg <= s_block_end;
                end
            end
            ST_ENV_HI, ST_PRES_HI: begin
                acc_reg <= acc_sum;
            end
            ST_PRES_DIFF: begin
                coef_reg <= COEF_W'(gain_reg);
                diff_reg <= $signed({2'b0, env_reg}) - $signed({2'b0, floor_reg, 16'b0});
                acc_reg  <= '0;
            end
            ST_PRES_SUM: begin
                if (!diff_pos) begin
                    pres_reg <= '0;
                end else if (acc_bits[ACC_W-1:28] > (ACC_W-28)'(PRES_MAX)) begin
                    pres_reg <= PRES_MAX;
                end else begin
                    pres_reg <= acc_bits[LEVEL_W+27:28];
                end
            end
            default: ;
        endcase
    end

    // Output register: load the result beat, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_presence_reg       <= pres_reg;
            m_envelope_level_reg <= env_reg[ENV_W-1:ENV_W-LEVEL_W];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_presence       = m_presence_reg;
    assign m_envelope_level = m_envelope_level_reg;

endmodule

`default_nettype wire
